[rtl/core/rgb_downscale_wb_fringe_top_assert.svh]
// Assertion macros used by the checker file of the downscaler.
`ifndef RGB_DOWNSCALE_WB_FRINGE_TOP_ASSERT_SVH
`define RGB_DOWNSCALE_WB_FRINGE_TOP_ASSERT_SVH

// Checked on every rising edge outside reset.
`define RDWF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RDWF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/rdwf_pkg.sv]
package rdwf_pkg;

  localparam int unsigned MaxInWidthDefault = 2048;
  localparam int unsigned PixW              = 8;
  localparam int unsigned SumW              = 9;
  localparam int unsigned GainW             = 16;
  localparam int unsigned OutWidthW         = 11;
  localparam int unsigned OutHeightW        = 12;
  localparam int unsigned RowW              = 12;
  localparam int unsigned InHeightW         = 13;
  localparam int unsigned MaxOutHeight      = 2048;
  localparam int unsigned QueueDepth        = 4;
  localparam int unsigned QueueCntW         = $clog2(QueueDepth + 1);
  localparam int unsigned CfgIdxW           = 3;
  localparam int unsigned CfgDataW          = 16;

  localparam int unsigned WbProdW    = PixW + GainW;
  localparam int unsigned FullProdW  = WbProdW + GainW;
  localparam int unsigned ScaledW    = 16;
  localparam int unsigned FracBits   = 24;
  localparam logic [ScaledW-1:0] BrightLimit = ScaledW'(220);

  localparam logic [OutWidthW-1:0]  OutWidthReset  = OutWidthW'(960);
  localparam logic [OutHeightW-1:0] OutHeightReset = OutHeightW'(540);
  localparam logic [GainW-1:0]      UnityGain      = GainW'(4096);

  typedef enum logic [CfgIdxW-1:0] {
    REG_OUT_WIDTH  = 3'd0,
    REG_OUT_HEIGHT = 3'd1,
    REG_RED_GAIN   = 3'd2,
    REG_GREEN_GAIN = 3'd3,
    REG_BLUE_GAIN  = 3'd4,
    REG_EXPOSURE   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [OutWidthW-1:0]  out_width;
    logic [OutHeightW-1:0] out_height;
  } frame_cfg_t;

  typedef struct packed {
    logic [GainW-1:0] red;
    logic [GainW-1:0] green;
    logic [GainW-1:0] blue;
    logic [GainW-1:0] exposure;
  } gain_cfg_t;

  // One 2x2 average waiting for the color stage.
  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
    logic            eol;
    logic            eof;
  } avg_item_t;

endpackage

[rtl/core/rdwf_if.sv]
interface rdwf_pix_if;
  logic                      valid;
  logic                      ready;
  logic [rdwf_pkg::PixW-1:0] red;
  logic [rdwf_pkg::PixW-1:0] green;
  logic [rdwf_pkg::PixW-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface rdwf_res_if;
  logic                      valid;
  logic                      ready;
  logic [rdwf_pkg::PixW-1:0] red_out;
  logic [rdwf_pkg::PixW-1:0] green_out;
  logic [rdwf_pkg::PixW-1:0] blue_out;
  logic                      end_of_line;
  logic                      end_of_frame;

  modport source (output valid, red_out, green_out, blue_out, end_of_line, end_of_frame,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, end_of_line, end_of_frame,
                output ready);
endinterface

[rtl/core/rgb_downscale_wb_fringe_top.sv]
// Path: the transaction of the bottom-right pixel of a 2x2 block is registered in the front's
// sum stage, then passes the queue and the color stages a, b, c and out; a stalled output holds it.
// Throughput: one input pixel per cycle while the queue has room; one result per four input pixels.
// A 4-entry queue between the averaging front and the 4-stage color pipe lets each stall alone.
// Reset: counters, the held left pixel and all valid flags clear, the registers take their
// defaults; the per-column row-sum memory is not cleared and needs no clearing pass.
module rgb_downscale_wb_fringe_top #(
  parameter int unsigned MAX_IN_WIDTH = rdwf_pkg::MaxInWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rdwf_pix_if.sink                      pix_in,
  rdwf_res_if.source                    pix_out,
  input  logic                          cfg_we_i,
  input  logic [rdwf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rdwf_pkg::CfgDataW-1:0] cfg_data_i
);

  rdwf_pkg::frame_cfg_t            frame_cfg_q;
  rdwf_pkg::gain_cfg_t             gain_cfg_q;
  logic                            push;
  logic                            pop;
  logic                            q_empty;
  logic [rdwf_pkg::QueueCntW-1:0]  q_count;
  rdwf_pkg::avg_item_t             push_item;
  rdwf_pkg::avg_item_t             pop_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cfg_q.out_width  <= rdwf_pkg::OutWidthReset;
      frame_cfg_q.out_height <= rdwf_pkg::OutHeightReset;
      gain_cfg_q.red         <= rdwf_pkg::UnityGain;
      gain_cfg_q.green       <= rdwf_pkg::UnityGain;
      gain_cfg_q.blue        <= rdwf_pkg::UnityGain;
      gain_cfg_q.exposure    <= rdwf_pkg::UnityGain;
    end else if (cfg_we_i) begin
      unique case (rdwf_pkg::cfg_reg_e'(cfg_idx_i))
        rdwf_pkg::REG_OUT_WIDTH: begin
          frame_cfg_q.out_width <= cfg_data_i[rdwf_pkg::OutWidthW-1:0];
        end
        rdwf_pkg::REG_OUT_HEIGHT: begin
          frame_cfg_q.out_height <= cfg_data_i[rdwf_pkg::OutHeightW-1:0];
        end
        rdwf_pkg::REG_RED_GAIN: begin
          gain_cfg_q.red <= cfg_data_i;
        end
        rdwf_pkg::REG_GREEN_GAIN: begin
          gain_cfg_q.green <= cfg_data_i;
        end
        rdwf_pkg::REG_BLUE_GAIN: begin
          gain_cfg_q.blue <= cfg_data_i;
        end
        rdwf_pkg::REG_EXPOSURE: begin
          gain_cfg_q.exposure <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  rdwf_front #(
    .MAX_IN_WIDTH(MAX_IN_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_cfg_i (frame_cfg_q),
    .pix_in      (pix_in),
    .q_count_i   (q_count),
    .push_o      (push),
    .item_o      (push_item)
  );

  rdwf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  rdwf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .gain_cfg_i (gain_cfg_q),
    .q_empty_i  (q_empty),
    .q_item_i   (pop_item),
    .pop_o      (pop),
    .pix_out    (pix_out)
  );

endmodule

[rtl/core/rdwf_fifo.sv]
module rdwf_fifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  rdwf_pkg::avg_item_t              item_i,
  input  logic                             pop_i,
  output rdwf_pkg::avg_item_t              item_o,
  output logic                             empty_o,
  output logic [rdwf_pkg::QueueCntW-1:0]   count_o
);

  localparam int unsigned PtrW = $clog2(rdwf_pkg::QueueDepth);

  rdwf_pkg::avg_item_t              store_q [rdwf_pkg::QueueDepth];
  logic [PtrW-1:0]                  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]                  rd_ptr_q, rd_ptr_d;
  logic [rdwf_pkg::QueueCntW-1:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + rdwf_pkg::QueueCntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - rdwf_pkg::QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o  = store_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

[rtl/core/rdwf_front.sv]
module rdwf_front #(
  parameter int unsigned MAX_IN_WIDTH = rdwf_pkg::MaxInWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rdwf_pkg::frame_cfg_t           frame_cfg_i,
  rdwf_pix_if.sink                       pix_in,
  input  logic [rdwf_pkg::QueueCntW-1:0] q_count_i,
  output logic                           push_o,
  output rdwf_pkg::avg_item_t            item_o
);

  localparam int unsigned SumDepth = MAX_IN_WIDTH / 2;
  localparam int unsigned ColW     = $clog2(MAX_IN_WIDTH);
  localparam int unsigned InWW     = ColW + 1;
  localparam int unsigned SlotW    = (SumDepth > 1) ? $clog2(SumDepth) : 1;
  localparam int unsigned EntryW   = 3 * rdwf_pkg::SumW;
  localparam int unsigned SumW     = rdwf_pkg::SumW;
  localparam int unsigned PixW     = rdwf_pkg::PixW;
  localparam int unsigned RowW     = rdwf_pkg::RowW;
  localparam int unsigned InHW     = rdwf_pkg::InHeightW;

  logic [EntryW-1:0]    sums_mem [SumDepth];
  logic [EntryW-1:0]    even_rd_q;

  logic [ColW-1:0]      col_q, col_d;
  logic [RowW-1:0]      row_q, row_d;
  logic [3*PixW-1:0]    left_q;

  logic                 s1_valid_q;
  logic [SumW-1:0]      s1_r_q, s1_g_q, s1_b_q;
  logic                 s1_eol_q, s1_eof_q;

  logic                 accept;
  logic [InWW-1:0]      in_w;
  logic [InHW-1:0]      in_h;
  logic [InWW-1:0]      col_inc;
  logic [InHW-1:0]      row_inc;
  logic                 last_col, last_row;
  logic                 odd_col, odd_row;
  logic [SlotW-1:0]     slot;
  logic [SumW-1:0]      rs, gs, bs;
  logic [SumW:0]        r_tot, g_tot, b_tot;

  // Room is counted for the average that is still on its way into the queue.
  assign pix_in.ready = ({1'b0, q_count_i} + {{rdwf_pkg::QueueCntW{1'b0}}, s1_valid_q})
                        < (rdwf_pkg::QueueCntW + 1)'(rdwf_pkg::QueueDepth);
  assign accept       = pix_in.valid & pix_in.ready;

  always_comb begin
    if (frame_cfg_i.out_width == '0) begin
      in_w = InWW'(2);
    end else if (32'(frame_cfg_i.out_width) > SumDepth) begin
      in_w = InWW'(2 * SumDepth);
    end else begin
      in_w = InWW'({frame_cfg_i.out_width, 1'b0});
    end
    if (frame_cfg_i.out_height == '0) begin
      in_h = InHW'(2);
    end else if (32'(frame_cfg_i.out_height) > rdwf_pkg::MaxOutHeight) begin
      in_h = InHW'(2 * rdwf_pkg::MaxOutHeight);
    end else begin
      in_h = {frame_cfg_i.out_height, 1'b0};
    end
  end

  assign col_inc  = {1'b0, col_q} + InWW'(1);
  assign row_inc  = {1'b0, row_q} + InHW'(1);
  // A counter left past a shrunk size also ends its row or frame.
  assign last_col = (col_inc >= in_w);
  assign last_row = (row_inc >= in_h);
  assign odd_col  = col_q[0];
  assign odd_row  = row_q[0];
  assign slot     = SlotW'(col_q >> 1);

  assign rs = {1'b0, left_q[3*PixW-1:2*PixW]} + {1'b0, pix_in.red};
  assign gs = {1'b0, left_q[2*PixW-1:PixW]}   + {1'b0, pix_in.green};
  assign bs = {1'b0, left_q[PixW-1:0]}        + {1'b0, pix_in.blue};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_inc[RowW-1:0];
      end else begin
        col_d = col_inc[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= accept & odd_col & odd_row;
      if (accept && !odd_col) begin
        left_q <= {pix_in.red, pix_in.green, pix_in.blue};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && odd_col) begin
      s1_r_q   <= rs;
      s1_g_q   <= gs;
      s1_b_q   <= bs;
      s1_eol_q <= last_col;
      s1_eof_q <= last_col & last_row;
    end
  end

  // Even rows park their pair sums per output column; odd rows fetch them.
  always_ff @(posedge clk_i) begin
    if (accept && odd_col && !odd_row) begin
      sums_mem[slot] <= {rs, gs, bs};
    end
    if (accept && odd_col && odd_row) begin
      even_rd_q <= sums_mem[slot];
    end
  end

  assign r_tot = {1'b0, s1_r_q} + {1'b0, even_rd_q[3*SumW-1:2*SumW]};
  assign g_tot = {1'b0, s1_g_q} + {1'b0, even_rd_q[2*SumW-1:SumW]};
  assign b_tot = {1'b0, s1_b_q} + {1'b0, even_rd_q[SumW-1:0]};

  assign push_o       = s1_valid_q;
  assign item_o.red   = r_tot[SumW:2];
  assign item_o.green = g_tot[SumW:2];
  assign item_o.blue  = b_tot[SumW:2];
  assign item_o.eol   = s1_eol_q;
  assign item_o.eof   = s1_eof_q;

endmodule

[rtl/core/rdwf_back.sv]
module rdwf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rdwf_pkg::gain_cfg_t   gain_cfg_i,
  input  logic                  q_empty_i,
  input  rdwf_pkg::avg_item_t   q_item_i,
  output logic                  pop_o,
  rdwf_res_if.source            pix_out
);

  localparam int unsigned WbW   = rdwf_pkg::WbProdW;
  localparam int unsigned FullW = rdwf_pkg::FullProdW;
  localparam int unsigned ScW   = rdwf_pkg::ScaledW;
  localparam int unsigned PixW  = rdwf_pkg::PixW;
  localparam int unsigned FracB = rdwf_pkg::FracBits;
  localparam logic [FullW-1:0] HalfLsb = FullW'(1) << (FracB - 1);

  function automatic logic [PixW-1:0] sat8(input logic [ScW-1:0] v);
    sat8 = (v > ScW'(255)) ? PixW'(255) : v[PixW-1:0];
  endfunction

  logic              en;
  logic              a_valid_q, b_valid_q, c_valid_q, out_valid_q;
  logic [WbW-1:0]    a_r_q, a_g_q, a_b_q;
  logic [FullW-1:0]  b_r_q, b_g_q, b_b_q;
  logic [ScW-1:0]    c_r_q, c_g_q, c_b_q;
  logic              a_eol_q, a_eof_q, b_eol_q, b_eof_q, c_eol_q, c_eof_q;
  logic [PixW-1:0]   out_r_q, out_g_q, out_b_q;
  logic              out_eol_q, out_eof_q;

  logic [FullW-1:0]  r_rnd, g_rnd, b_rnd;
  logic [ScW-1:0]    mx;
  logic [ScW+2:0]    g_side, mx_side;
  logic              fringe;
  logic [ScW:0]      r_mix, b_mix;
  logic [ScW-1:0]    r_fin, b_fin;

  // The whole pipe moves together and holds while a result waits.
  assign en    = ~out_valid_q | pix_out.ready;
  assign pop_o = ~q_empty_i & en;

  assign r_rnd = b_r_q + HalfLsb;
  assign g_rnd = b_g_q + HalfLsb;
  assign b_rnd = b_b_q + HalfLsb;

  // g < floor(3*mx/5) is the same as 5*g + 5 <= 3*mx for integers.
  assign mx      = (c_r_q > c_b_q) ? c_r_q : c_b_q;
  assign g_side  = {3'b0, c_g_q} + {1'b0, c_g_q, 2'b0} + (ScW + 3)'(5);
  assign mx_side = {3'b0, mx} + {2'b0, mx, 1'b0};
  assign fringe  = (g_side <= mx_side) &&
                   ((c_r_q > rdwf_pkg::BrightLimit) || (c_b_q > rdwf_pkg::BrightLimit));
  assign r_mix   = {1'b0, c_r_q} + {1'b0, c_g_q};
  assign b_mix   = {1'b0, c_b_q} + {1'b0, c_g_q};
  assign r_fin   = fringe ? r_mix[ScW:1] : c_r_q;
  assign b_fin   = fringe ? b_mix[ScW:1] : c_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q   <= pop_o;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= b_valid_q;
      out_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_r_q     <= WbW'(q_item_i.red) * WbW'(gain_cfg_i.red);
      a_g_q     <= WbW'(q_item_i.green) * WbW'(gain_cfg_i.green);
      a_b_q     <= WbW'(q_item_i.blue) * WbW'(gain_cfg_i.blue);
      a_eol_q   <= q_item_i.eol;
      a_eof_q   <= q_item_i.eof;

      b_r_q     <= FullW'(a_r_q) * FullW'(gain_cfg_i.exposure);
      b_g_q     <= FullW'(a_g_q) * FullW'(gain_cfg_i.exposure);
      b_b_q     <= FullW'(a_b_q) * FullW'(gain_cfg_i.exposure);
      b_eol_q   <= a_eol_q;
      b_eof_q   <= a_eof_q;

      c_r_q     <= r_rnd[FracB+ScW-1:FracB];
      c_g_q     <= g_rnd[FracB+ScW-1:FracB];
      c_b_q     <= b_rnd[FracB+ScW-1:FracB];
      c_eol_q   <= b_eol_q;
      c_eof_q   <= b_eof_q;

      out_r_q   <= sat8(r_fin);
      out_g_q   <= sat8(c_g_q);
      out_b_q   <= sat8(b_fin);
      out_eol_q <= c_eol_q;
      out_eof_q <= c_eof_q;
    end
  end

  assign pix_out.valid        = out_valid_q;
  assign pix_out.red_out      = out_r_q;
  assign pix_out.green_out    = out_g_q;
  assign pix_out.blue_out     = out_b_q;
  assign pix_out.end_of_line  = out_eol_q;
  assign pix_out.end_of_frame = out_eof_q;

endmodule

[rtl/core/rdwf_checker.sv]
`include "rgb_downscale_wb_fringe_top_assert.svh"

module rdwf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_eol_i,
  input logic out_eof_i
);

  // A result that is not taken stays offered.
  `RDWF_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")
  // The last pixel of a frame is also the last of its row.
  `RDWF_ASSERT(a_eof_eol, clk_i, rst_ni, out_valid_i && out_eof_i |-> out_eol_i, "end of frame without end of line")
  `RDWF_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !out_valid_i, "result offered during reset")
  // With the queue empty the input side must be ready right after reset.
  `RDWF_ASSERT_ALWAYS(a_rst_ready, clk_i, $rose(rst_ni) |-> in_ready_i, "input not ready after reset")

endmodule

bind rgb_downscale_wb_fringe_top rdwf_checker u_rdwf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pix_in.ready),
  .out_valid_i (pix_out.valid),
  .out_ready_i (pix_out.ready),
  .out_eol_i   (pix_out.end_of_line),
  .out_eof_i   (pix_out.end_of_frame)
);
